// File: src/mcsc_pkg.sv
package mcsc_pkg;

  localparam int WHEELS      = 4;
  localparam int WHEEL_W     = 2;
  localparam int STEP_W      = 5;
  localparam int LAST_STEP   = 17;
  localparam int DRIVE_MAX   = 16384;
  localparam int RPM_FACTOR  = 38217;
  localparam int HEADING_MAX = 8191;

  localparam logic [2:0] REG_KP      = 3'd0;
  localparam logic [2:0] REG_KD      = 3'd1;
  localparam logic [2:0] REG_RAMP    = 3'd2;
  localparam logic [2:0] REG_HEADING = 3'd3;
  localparam logic [2:0] REG_WLIMIT  = 3'd4;
  localparam logic [2:0] REG_SMOOTH  = 3'd5;
  localparam logic [2:0] REG_ARM     = 3'd6;

  typedef struct packed {
    logic [7:0]  kp_gain;
    logic [7:0]  kd_gain;
    logic [14:0] ramp_limit;
    logic [12:0] heading_offset;
    logic [14:0] wheel_speed_limit;
    logic [11:0] smooth_step;
    logic [12:0] yaw_arm;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_W, OP_CVX, OP_SVY, OP_CVY, OP_SVX, OP_RPM, OP_KP, OP_KD
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [WHEEL_W-1:0] wheel;
  } step_op_t;

  typedef struct packed {
    logic     accept;
    step_op_t mop;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_TABLE, ST_RUN, ST_DRAIN, ST_FINISH
  } state_t;

  // rotation first, one gap for the last rotation write-back, then rpm and wheel loops
  function automatic step_op_t step_op(logic [STEP_W-1:0] step);
    step_op_t r;
    logic [STEP_W-1:0] rel;
    r.wheel = '0;
    rel = step - STEP_W'(10);
    unique case (step)
      5'd0:    r.op = OP_W;
      5'd1:    r.op = OP_CVX;
      5'd2:    r.op = OP_SVY;
      5'd3:    r.op = OP_CVY;
      5'd4:    r.op = OP_SVX;
      5'd6, 5'd7, 5'd8, 5'd9: begin
        r.op    = OP_RPM;
        r.wheel = WHEEL_W'(step - STEP_W'(6));
      end
      5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17: begin
        r.op    = rel[0] ? OP_KD : OP_KP;
        r.wheel = rel[WHEEL_W:1];
      end
      default: r.op = OP_NONE;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] sine_entry(int k, int bits);
    longint q, z, z2, r;
    int qb;
    qb = bits - 2;
    q  = (k >> qb) & 3;
    z  = longint'(k & ((1 << qb) - 1)) << (15 - qb);
    if (q == 1 || q == 3) z = 32768 - z;
    z2 = (z * z) >> 15;
    r  = (2320 * z2) >> 15;
    r  = 21024 - r;
    r  = (r * z2) >> 15;
    r  = 51472 - r;
    r  = (r * z) >> 15;
    r  = (r + 1) >> 1;
    if (r < 0) r = 0;
    if (r > 16384) r = 16384;
    if (q >= 2) r = -r;
    return r[15:0];
  endfunction

  function automatic logic signed [15:0] smooth_axis(logic signed [15:0] s,
                                                     logic signed [15:0] t,
                                                     logic [11:0] step);
    logic signed [17:0] v, mag, te;
    te  = 18'(t);
    mag = t[15] ? -te : te;
    if (t > 0) v = 18'(s) + $signed({6'd0, step});
    else if (t < 0) v = 18'(s) - $signed({6'd0, step});
    else v = '0;
    if (v > mag) v = mag;
    if (v < -mag) v = -mag;
    if (v > 18'sd32767) v = 18'sd32767;
    return v[15:0];
  endfunction

endpackage

// File: src/mecanum_chassis_speed_controller.sv
// The block takes one input word at a time; the next word is taken only after the
// result is in the output register. A single 18x18 multiplier is stepped through
// rotation, rpm scaling and the four wheel loops (18 slots), plus the accept,
// table read, drain and hand-off states.
// A finished result waits in the output register while the next word is taken.
// Reset (rst, synchronous) clears the smoothed targets, wheel accumulators and
// previous wheel speeds, and restores the register defaults.
module mecanum_chassis_speed_controller import mcsc_pkg::*; #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // target_vx, target_vy, target_vz, yaw_position, wheel_speed_0..3
  input  logic [127:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // drive_0, drive_1, drive_2, drive_3
  output logic [63:0]  m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  mcsc_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  mcsc_ctrl u_ctrl (
    .clk, .rst, .s_tvalid, .s_tready, .m_tready, .status, .cmd
  );

  mcsc_dp #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_dp (
    .clk, .rst, .cfg, .cmd, .status, .s_tdata, .m_tdata, .m_tvalid, .m_tready
  );

endmodule

// File: src/mcsc_cfg.sv
module mcsc_cfg import mcsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic wr;
  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp_gain           <= 8'd3;
      cfg.kd_gain           <= 8'd14;
      cfg.ramp_limit        <= 15'd461;
      cfg.heading_offset    <= 13'd5750;
      cfg.wheel_speed_limit <= 15'd14336;
      cfg.smooth_step       <= 12'd41;
      cfg.yaw_arm           <= 13'd1413;
    end else if (wr) begin
      unique case (paddr[4:2])
        REG_KP:      cfg.kp_gain           <= pwdata[7:0];
        REG_KD:      cfg.kd_gain           <= pwdata[7:0];
        REG_RAMP:    cfg.ramp_limit        <= pwdata[14:0];
        REG_HEADING: cfg.heading_offset    <= pwdata[12:0];
        REG_WLIMIT:  cfg.wheel_speed_limit <= pwdata[14:0];
        REG_SMOOTH:  cfg.smooth_step       <= pwdata[11:0];
        REG_ARM:     cfg.yaw_arm           <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_KP:      prdata = {24'd0, cfg.kp_gain};
      REG_KD:      prdata = {24'd0, cfg.kd_gain};
      REG_RAMP:    prdata = {17'd0, cfg.ramp_limit};
      REG_HEADING: prdata = {19'd0, cfg.heading_offset};
      REG_WLIMIT:  prdata = {17'd0, cfg.wheel_speed_limit};
      REG_SMOOTH:  prdata = {20'd0, cfg.smooth_step};
      REG_ARM:     prdata = {19'd0, cfg.yaw_arm};
      default:     prdata = '0;
    endcase
  end

endmodule

// File: src/mcsc_ctrl.sv
module mcsc_ctrl import mcsc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  logic    m_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;
  logic [STEP_W-1:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next   = state;
    step_next    = step;
    s_tready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.mop.op   = OP_NONE;
    cmd.mop.wheel = '0;
    cmd.load_out = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        if (s_tvalid) state_next = ST_TABLE;
      end
      ST_TABLE: begin
        step_next  = '0;
        state_next = ST_RUN;
      end
      ST_RUN: begin
        cmd.mop = step_op(step);
        if (step == STEP_W'(LAST_STEP)) state_next = ST_DRAIN;
        else step_next = step + 1'b1;
      end
      ST_DRAIN: state_next = ST_FINISH;
      ST_FINISH: begin
        // hold the result until the output register frees up
        if (!status.out_full || m_tready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: src/mcsc_dp.sv
module mcsc_dp import mcsc_pkg::*; #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  cmd_t         cmd,
  output status_t      status,
  input  logic [127:0] s_tdata,
  output logic [63:0]  m_tdata,
  output logic         m_tvalid,
  input  logic         m_tready
);

  localparam int TBL = 1 << SINE_TABLE_BITS;
  localparam int IW  = 14 + SINE_TABLE_BITS;

  logic signed [15:0] rom [TBL];
  for (genvar g = 0; g < TBL; g++) begin : g_rom
    assign rom[g] = sine_entry(g, SINE_TABLE_BITS);
  end

  logic signed [15:0] sm [3];
  logic signed [15:0] meas [WHEELS];
  logic signed [15:0] prev [WHEELS];
  logic signed [15:0] acc [WHEELS];
  logic signed [15:0] rpm [WHEELS];
  logic [SINE_TABLE_BITS-1:0] idx;
  logic signed [15:0] sin_q, cos_q;
  logic signed [17:0] vxc, vyc, wz;
  logic signed [31:0] rx;
  logic signed [27:0] tmp;
  logic signed [17:0] mul_a, mul_b;
  logic signed [35:0] prod;
  step_op_t ptag;

  logic [13:0] pos_sum, pos;
  logic [12:0] delta;
  logic [IW-1:0] num;
  logic signed [19:0] tgt_raw [WHEELS];
  logic signed [17:0] tgt [WHEELS];
  logic signed [17:0] setp [WHEELS];
  logic signed [17:0] err [WHEELS];
  logic signed [17:0] dm [WHEELS];
  logic signed [19:0] lim;
  logic signed [17:0] ramp;
  logic signed [35:0] sum_rot, rnd;
  logic signed [27:0] accv;

  assign status.out_full = m_tvalid;

  always_comb begin
    pos_sum = {1'b0, s_tdata[60:48]} + {1'b0, cfg.heading_offset};
    pos     = (pos_sum > 14'(HEADING_MAX)) ? pos_sum - 14'(HEADING_MAX) : pos_sum;
    delta   = 13'(14'(HEADING_MAX) - pos);
    num     = (IW'(delta) << SINE_TABLE_BITS) + IW'(4096);
  end

  // wheel targets from the chassis-frame velocities, then wheel loop errors and speed deltas
  always_comb begin
    lim = $signed({5'd0, cfg.wheel_speed_limit});
    tgt_raw[0] = 20'(vyc) + 20'(vxc) - 20'(wz);
    tgt_raw[1] = -20'(vyc) + 20'(vxc) - 20'(wz);
    tgt_raw[2] = 20'(vyc) + 20'(vxc) + 20'(wz);
    tgt_raw[3] = -20'(vyc) + 20'(vxc) + 20'(wz);
    for (int k = 0; k < WHEELS; k++) begin
      if (tgt_raw[k] > lim) tgt[k] = lim[17:0];
      else if (tgt_raw[k] < -lim) tgt[k] = 18'(-lim);
      else tgt[k] = tgt_raw[k][17:0];
    end
    setp[0] = -18'(rpm[2]);
    setp[1] = 18'(rpm[1]);
    setp[2] = 18'(rpm[0]);
    setp[3] = -18'(rpm[3]);
    ramp = $signed({3'd0, cfg.ramp_limit});
    for (int k = 0; k < WHEELS; k++) begin
      err[k] = setp[k] - 18'(meas[k]);
      if (err[k] > ramp) err[k] = ramp;
      else if (err[k] < -ramp) err[k] = -ramp;
      dm[k] = 18'(meas[k]) - 18'(prev[k]);
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mop.op)
      OP_W:   begin mul_a = 18'(sm[2]); mul_b = $signed({5'd0, cfg.yaw_arm}); end
      OP_CVX: begin mul_a = 18'(cos_q); mul_b = 18'(sm[0]); end
      OP_SVY: begin mul_a = 18'(sin_q); mul_b = 18'(sm[1]); end
      OP_CVY: begin mul_a = 18'(cos_q); mul_b = 18'(sm[1]); end
      OP_SVX: begin mul_a = 18'(sin_q); mul_b = 18'(sm[0]); end
      OP_RPM: begin mul_a = tgt[cmd.mop.wheel]; mul_b = 18'(RPM_FACTOR); end
      OP_KP:  begin mul_a = err[cmd.mop.wheel]; mul_b = $signed({10'd0, cfg.kp_gain}); end
      OP_KD:  begin mul_a = dm[cmd.mop.wheel]; mul_b = $signed({10'd0, cfg.kd_gain}); end
      default: ;
    endcase
  end

  always_comb begin
    sum_rot = (ptag.op == OP_SVY) ? 36'(rx) + prod : 36'(rx) - prod;
    case (ptag.op)
      OP_W:   rnd = (prod + 36'sd2048) >>> 12;
      OP_RPM: rnd = (prod + 36'sd32768) >>> 16;
      default: rnd = (sum_rot + 36'sd8192) >>> 14;
    endcase
    accv = tmp - prod[27:0];
    if (accv > 28'(DRIVE_MAX)) accv = 28'(DRIVE_MAX);
    else if (accv < -28'(DRIVE_MAX)) accv = -28'(DRIVE_MAX);
  end

  always_ff @(posedge clk) begin
    sin_q <= rom[idx];
    cos_q <= rom[idx + SINE_TABLE_BITS'(TBL >> 2)];
    prod  <= mul_a * mul_b;
    if (cmd.accept) begin
      idx <= num[13 +: SINE_TABLE_BITS];
      for (int k = 0; k < WHEELS; k++) meas[k] <= s_tdata[61 + 16*k +: 16];
    end
    case (ptag.op)
      OP_W:   wz  <= rnd[17:0];
      OP_CVX: rx  <= prod[31:0];
      OP_SVY: vxc <= rnd[17:0];
      OP_CVY: rx  <= prod[31:0];
      OP_SVX: vyc <= rnd[17:0];
      OP_RPM: rpm[ptag.wheel] <= rnd[15:0];
      OP_KP:  tmp <= 28'(acc[ptag.wheel]) + prod[27:0];
      default: ;
    endcase
    if (cmd.load_out) begin
      for (int k = 0; k < WHEELS; k++) m_tdata[16*k +: 16] <= acc[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptag     <= '{op: OP_NONE, wheel: '0};
      m_tvalid <= 1'b0;
      for (int k = 0; k < 3; k++) sm[k] <= '0;
      for (int k = 0; k < WHEELS; k++) begin
        acc[k]  <= '0;
        prev[k] <= '0;
      end
    end else begin
      ptag <= cmd.mop;
      if (cmd.load_out) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (cmd.accept) begin
        for (int k = 0; k < 3; k++) begin
          sm[k] <= smooth_axis(sm[k], s_tdata[16*k +: 16], cfg.smooth_step);
        end
      end
      if (ptag.op == OP_KD) begin
        acc[ptag.wheel]  <= accv[15:0];
        prev[ptag.wheel] <= meas[ptag.wheel];
      end
    end
  end

endmodule

// File: bench/tb.sv
module tb import mcsc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  class drive_scoreboard;
    cfg_t                cfg;
    longint              smoothed [3];
    longint              wheel_acc [WHEELS];
    longint              last_speed [WHEELS];
    longint              sine [1024];
    logic [63:0]         pending [$];
    int                  errors;

    function new();
      longint q, z, z2, r;
      for (int k = 0; k < 1024; k++) begin
        q = (k >> 8) & 3;
        z = longint'(k & 255) << 7;
        if (q == 1 || q == 3) z = 32768 - z;
        z2 = (z * z) >>> 15;
        r  = 21024 - ((2320 * z2) >>> 15);
        r  = 51472 - ((r * z2) >>> 15);
        r  = (((r * z) >>> 15) + 1) >>> 1;
        r  = clip(r, 0, 16384);
        sine[k] = (q >= 2) ? -r : r;
      end
      cfg = '{kp_gain: 8'd3, kd_gain: 8'd14, ramp_limit: 15'd461,
              heading_offset: 13'd5750, wheel_speed_limit: 15'd14336,
              smooth_step: 12'd41, yaw_arm: 13'd1413};
      for (int k = 0; k < 3; k++) smoothed[k] = 0;
      for (int k = 0; k < WHEELS; k++) begin
        wheel_acc[k] = 0;
        last_speed[k] = 0;
      end
      errors = 0;
    endfunction

    function longint clip(longint x, longint lo, longint hi);
      if (x < lo) return lo;
      if (x > hi) return hi;
      return x;
    endfunction

    // round half up, arithmetic shift floors
    function longint rshift(longint x, int n);
      return (x + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function longint slew(longint s, longint t);
      longint mag;
      mag = (t < 0) ? -t : t;
      if (t > 0) s = s + cfg.smooth_step;
      else if (t < 0) s = s - cfg.smooth_step;
      else s = 0;
      s = clip(s, -mag, mag);
      return clip(s, -32768, 32767);
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_KP:      cfg.kp_gain = v[7:0];
        REG_KD:      cfg.kd_gain = v[7:0];
        REG_RAMP:    cfg.ramp_limit = v[14:0];
        REG_HEADING: cfg.heading_offset = v[12:0];
        REG_WLIMIT:  cfg.wheel_speed_limit = v[14:0];
        REG_SMOOTH:  cfg.smooth_step = v[11:0];
        REG_ARM:     cfg.yaw_arm = v[12:0];
        default: ;
      endcase
    endfunction

    function void note_input(logic [127:0] d);
      longint vx, vy, vz, s, c, vxc, vyc, w, lim, meas, err, acc;
      longint tgt [WHEELS];
      longint setp [WHEELS];
      longint pos, delta, idx;
      logic [63:0] res;
      smoothed[0] = slew(smoothed[0], longint'($signed(d[15:0])));
      smoothed[1] = slew(smoothed[1], longint'($signed(d[31:16])));
      smoothed[2] = slew(smoothed[2], longint'($signed(d[47:32])));
      vx = smoothed[0];
      vy = smoothed[1];
      vz = smoothed[2];
      pos = longint'(d[60:48]) + cfg.heading_offset;
      if (pos > 8191) pos = pos - 8191;
      delta = 8191 - pos;
      idx = (((delta << 10) + 4096) >> 13) & 1023;
      s = sine[idx];
      c = sine[(idx + 256) & 1023];
      vxc = rshift(c * vx + s * vy, 14);
      vyc = rshift(c * vy - s * vx, 14);
      w   = rshift(vz * cfg.yaw_arm, 12);
      tgt[0] = vyc + vxc - w;
      tgt[1] = -vyc + vxc - w;
      tgt[2] = vyc + vxc + w;
      tgt[3] = -vyc + vxc + w;
      lim = cfg.wheel_speed_limit;
      for (int k = 0; k < WHEELS; k++)
        tgt[k] = rshift(clip(tgt[k], -lim, lim) * 38217, 16);
      // wheel remap and sign
      setp[0] = -tgt[2];
      setp[1] = tgt[1];
      setp[2] = tgt[0];
      setp[3] = -tgt[3];
      for (int k = 0; k < WHEELS; k++) begin
        meas = longint'($signed(d[61 + 16*k +: 16]));
        err  = clip(setp[k] - meas, -longint'(cfg.ramp_limit), longint'(cfg.ramp_limit));
        acc  = wheel_acc[k] + cfg.kp_gain * err - cfg.kd_gain * (meas - last_speed[k]);
        acc  = clip(acc, -16384, 16384);
        wheel_acc[k] = acc;
        last_speed[k] = meas;
        res[16*k +: 16] = acc[15:0];
      end
      pending.push_back(res);
    endfunction

    function void check_result(logic [63:0] r);
      logic [63:0] e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected drive word %h", $realtime, r);
        errors++;
        return;
      end
      e = pending.pop_front();
      for (int k = 0; k < WHEELS; k++)
        if (e[16*k +: 16] !== r[16*k +: 16]) begin
          $display("%0t: drive_%0d expected %0d got %0d", $realtime, k,
                   $signed(e[16*k +: 16]), $signed(r[16*k +: 16]));
          errors++;
        end
    endfunction
  endclass

  logic         clk, rst;
  logic         s_tvalid, s_tready, m_tvalid, m_tready;
  logic [127:0] s_tdata;
  logic [63:0]  m_tdata;
  logic         psel, penable, pwrite, pready;
  logic [4:0]   paddr;
  logic [31:0]  pwdata, prdata;

  drive_scoreboard sb;
  int  drives_seen;
  bit  held_off;

  mecanum_chassis_speed_controller DUT (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tb: errors");
    $finish;
  end

  function automatic logic [127:0] pack_tick(logic [15:0] vx, logic [15:0] vy,
      logic [15:0] vz, logic [12:0] yaw, logic [15:0] w0, logic [15:0] w1,
      logic [15:0] w2, logic [15:0] w3);
    return {3'b0, w3, w2, w1, w0, yaw, vz, vy, vx};
  endfunction

  function automatic logic [15:0] rand_speed();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 4000)) - 16'd2000;
      2: return 16'($urandom_range(0, 400)) - 16'd200;
      default: return 16'($urandom_range(0, 30000)) - 16'd15000;
    endcase
  endfunction

  function automatic logic [15:0] rand_target();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'($urandom);
      2: return 16'h8000;
      default: return 16'($urandom_range(0, 16000)) - 16'd8000;
    endcase
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    sb.write_reg(idx, v);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic send_tick(logic [127:0] d);
    int gap;
    gap = ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(20, 60);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= d;
    do @(posedge clk); while (!s_tready);
    sb.note_input(d);
  endtask

  // wait for the block to drain before touching registers
  task automatic settle();
    if (s_tvalid) s_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic random_regs();
    write_reg(REG_KP, $urandom_range(0, 255));
    write_reg(REG_KD, $urandom_range(0, 255));
    write_reg(REG_RAMP, $urandom_range(0, 32767));
    write_reg(REG_HEADING, $urandom_range(0, 8191));
    write_reg(REG_WLIMIT, $urandom_range(0, 32767));
    write_reg(REG_SMOOTH, $urandom_range(0, 4095));
    write_reg(REG_ARM, $urandom_range(0, 8191));
  endtask

  task automatic random_ticks(int n);
    for (int i = 0; i < n; i++)
      send_tick(pack_tick(rand_target(), rand_target(), rand_target(),
                          13'($urandom), rand_speed(), rand_speed(),
                          rand_speed(), rand_speed()));
  endtask

  // receiver: random stalls, one long hold-off to back the block up
  initial begin
    int stall;
    stall = 0;
    m_tready <= 0;
    @(posedge clk iff !rst);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        sb.check_result(m_tdata);
        drives_seen++;
      end
      if (stall > 0) begin
        stall--;
        m_tready <= 0;
      end else if (drives_seen >= 40 && !held_off) begin
        held_off = 1;
        stall = 400;
        m_tready <= 0;
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2:  stall = $urandom_range(1, 3);
          3:        stall = $urandom_range(20, 80);
          default:  stall = 0;
        endcase
        m_tready <= (stall == 0);
      end
    end
  end

  initial begin
    sb = new();
    drives_seen = 0;
    held_off = 0;
    rst <= 1; s_tvalid <= 0; s_tdata <= '0;
    psel <= 0; penable <= 0; pwrite <= 0; paddr <= '0; pwdata <= '0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed ticks at reset settings: extremes, zero targets, heading wrap
    send_tick(pack_tick(16'd0, 16'd0, 16'd0, 13'd0, 16'd0, 16'd0, 16'd0, 16'd0));
    for (int i = 0; i < 4; i++)
      send_tick(pack_tick(16'h7fff, 16'h7fff, 16'h7fff, 13'd8191,
                          16'h7fff, 16'h8000, 16'h7fff, 16'h8000));
    for (int i = 0; i < 4; i++)
      send_tick(pack_tick(16'h8000, 16'h8000, 16'h8000, 13'd2441,
                          16'h8000, 16'h7fff, 16'h8000, 16'h7fff));
    send_tick(pack_tick(16'd0, 16'h8000, 16'd1, 13'd2442, 16'd0, 16'd0, 16'd0, 16'd0));
    send_tick(pack_tick(16'h1000, 16'd0, 16'hffff, 13'd4096,
                        16'd100, 16'hff9c, 16'd0, 16'd1));
    settle();
    write_reg(REG_KP, 255); write_reg(REG_KD, 255); write_reg(REG_RAMP, 32767);
    write_reg(REG_HEADING, 8191); write_reg(REG_WLIMIT, 32767);
    write_reg(REG_SMOOTH, 4095); write_reg(REG_ARM, 8191);
    for (int i = 0; i < 3; i++)
      send_tick(pack_tick(16'h7fff, 16'h8000, 16'h7fff, 13'd1, 16'h8000,
                          16'h8000, 16'h7fff, 16'h7fff));
    send_tick(pack_tick(16'h8000, 16'h7fff, 16'h8000, 13'd8191, 16'h7fff,
                        16'h7fff, 16'h8000, 16'h8000));
    random_ticks(90);
    settle();
    write_reg(REG_KP, 0); write_reg(REG_KD, 0); write_reg(REG_RAMP, 0);
    write_reg(REG_HEADING, 0); write_reg(REG_WLIMIT, 0);
    write_reg(REG_SMOOTH, 0); write_reg(REG_ARM, 0);
    random_ticks(30);
    settle();
    write_reg(REG_RAMP, 16384);
    write_reg(REG_KP, 1);
    write_reg(REG_KD, 1);
    random_ticks(60);
    for (int p = 0; p < 3; p++) begin
      settle();
      random_regs();
      random_ticks(90);
    end
    settle();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
